### rtl/core/scsr_pkg.sv
// ----------------------------------------------------------------------------
// scsr_pkg
// Shared types, opcodes and the register offset map of the command stream
// retargeter.
// ----------------------------------------------------------------------------
package scsr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  OP_WAIT16    = 8'h61;
    localparam logic [7:0]  OP_WAIT735   = 8'h62;
    localparam logic [7:0]  OP_WAIT882   = 8'h63;
    localparam logic [7:0]  OP_END       = 8'h66;
    localparam logic [7:0]  OP_REGWR     = 8'hB3;
    localparam logic [3:0]  OP_WAITN_HI  = 4'h7;
    localparam logic [15:0] SAMPLES_735  = 16'd735;
    localparam logic [15:0] SAMPLES_882  = 16'd882;
    localparam logic [7:0]  WAVE_BASE    = 8'h90;
    localparam logic [7:0]  REG_NR30     = 8'h70;
    localparam logic [7:0]  REG_NR32     = 8'h73;
    localparam logic [7:0]  MASK_NR30    = 8'h80;
    localparam logic [7:0]  MASK_NR32    = 8'h60;
    localparam logic [7:0]  WAVE_FIX_VAL = 8'h40;
    localparam logic [31:0] POS_RESET    = 32'h0000_00C0;
    localparam logic [15:0] TPS_RESET    = 16'd380;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CMD = 2'd1;
    localparam logic [1:0] ST_BAD_REG = 2'd2;
    localparam logic [1:0] ST_ZERO_WT = 2'd3;

    localparam logic REG_IDX_LOOP = 1'b0;
    localparam logic REG_IDX_TPS  = 1'b1;

    typedef enum logic [1:0] {
        K_WAIT,
        K_REG,
        K_END,
        K_ERR
    } t_kind;

    // One classified command handed from the parser to the emitter.
    //   K_WAIT: data[15:0] = sample count
    //   K_REG : aux = mapped offset, data[7:0] = masked data, flag = wave RAM
    //   K_END : data = loop position, flag = loop found, pad = zero fill
    //   K_ERR : data[1:0] = status
    typedef struct packed {
        t_kind       kind;
        logic [31:0] data;
        logic [7:0]  aux;
        logic        flag;
        logic [3:0]  pad;
    } t_job;

    // Mapped offset for source offsets 0x00..0x2F, zero when unknown.
    function automatic logic [7:0] map_reg(input logic [7:0] off);
        logic [7:0] res;
        res = 8'h00;
        if (off[7:4] == 4'h2) begin
            res = WAVE_BASE | {4'h0, off[3:0]};
        end else if (off[7:5] == 3'd0) begin
            case (off[4:0])
                5'h00: res = 8'h60;
                5'h01: res = 8'h62;
                5'h02: res = 8'h63;
                5'h03: res = 8'h64;
                5'h04: res = 8'h65;
                5'h06: res = 8'h68;
                5'h07: res = 8'h69;
                5'h08: res = 8'h6C;
                5'h09: res = 8'h6D;
                5'h0A: res = 8'h70;
                5'h0B: res = 8'h72;
                5'h0C: res = 8'h73;
                5'h0D: res = 8'h74;
                5'h0E: res = 8'h75;
                5'h10: res = 8'h78;
                5'h11: res = 8'h79;
                5'h12: res = 8'h7C;
                5'h13: res = 8'h7D;
                5'h14: res = 8'h80;
                5'h15: res = 8'h81;
                5'h16: res = 8'h84;
                default: res = 8'h00;
            endcase
        end
        return res;
    endfunction

endpackage

### rtl/core/scsr_front.sv
// ----------------------------------------------------------------------------
// scsr_front
// Command parser: takes stream bytes, tracks the output count and the loop
// point, and pushes one classified job per result-producing byte.
// ----------------------------------------------------------------------------
module scsr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_stream_byte,
    input  logic [31:0]          i_loop_offset,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_job_valid,
    output scsr_pkg::t_job       o_job
);

    typedef enum logic [2:0] {
        PH_CMD,
        PH_WLO,
        PH_WHI,
        PH_ROFF,
        PH_RDAT
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_operand,   n_operand;
    logic [31:0] r_pos,       n_pos;
    logic [31:0] r_cnt,       n_cnt;
    logic [31:0] r_loop_pos,  n_loop_pos;
    logic        r_loop_seen, n_loop_seen;
    logic        r_stopped,   n_stopped;

    logic        w_accept;
    logic [7:0]  w_map;
    logic [7:0]  w_data;
    logic        w_wave;
    logic [3:0]  w_fill;

    assign o_full   = !r_stopped && i_q_full;
    assign w_accept = i_push && !o_full && !r_stopped;
    assign w_map    = scsr_pkg::map_reg(i_stream_byte);
    assign w_wave   = (r_operand[7:4] == scsr_pkg::WAVE_BASE[7:4]);
    // Count after the end mark and loop bytes, then fill up to a multiple of 16.
    assign w_fill   = 4'(4'd0 - (r_cnt[3:0] + 4'd5));

    always_comb begin
        w_data = i_stream_byte;
        if (r_operand == scsr_pkg::REG_NR30) begin
            w_data = i_stream_byte & scsr_pkg::MASK_NR30;
        end else if (r_operand == scsr_pkg::REG_NR32) begin
            w_data = i_stream_byte & scsr_pkg::MASK_NR32;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_operand   = r_operand;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_loop_pos  = r_loop_pos;
        n_loop_seen = r_loop_seen;
        n_stopped   = r_stopped;
        o_job_valid = 1'b0;
        o_job       = '{kind: scsr_pkg::K_ERR, data: 32'd0, aux: 8'd0,
                        flag: 1'b0, pad: 4'd0};
        if (w_accept) begin
            n_pos = r_pos + 32'd1;
            case (r_phase)
                PH_WLO: begin
                    n_operand = i_stream_byte;
                    n_phase   = PH_WHI;
                end
                PH_WHI: begin
                    n_phase     = PH_CMD;
                    o_job_valid = 1'b1;
                    if ({i_stream_byte, r_operand} == 16'd0) begin
                        o_job.data = {30'd0, scsr_pkg::ST_ZERO_WT};
                        n_stopped  = 1'b1;
                    end else begin
                        o_job.kind = scsr_pkg::K_WAIT;
                        o_job.data = {16'd0, i_stream_byte, r_operand};
                        n_cnt      = r_cnt + 32'd5;
                    end
                end
                PH_ROFF: begin
                    if (w_map == 8'd0) begin
                        o_job_valid = 1'b1;
                        o_job.data  = {30'd0, scsr_pkg::ST_BAD_REG};
                        n_stopped   = 1'b1;
                    end else begin
                        n_operand = w_map;
                        n_phase   = PH_RDAT;
                    end
                end
                PH_RDAT: begin
                    n_phase     = PH_CMD;
                    o_job_valid = 1'b1;
                    o_job.kind  = scsr_pkg::K_REG;
                    o_job.aux   = r_operand;
                    o_job.data  = {24'd0, w_data};
                    o_job.flag  = w_wave;
                    n_cnt       = r_cnt + (w_wave ? 32'd6 : 32'd3);
                end
                default: begin
                    n_phase = PH_CMD;
                    if (i_stream_byte == scsr_pkg::OP_END) begin
                        o_job_valid = 1'b1;
                        o_job.kind  = scsr_pkg::K_END;
                        o_job.data  = r_loop_pos;
                        o_job.flag  = r_loop_seen;
                        o_job.pad   = w_fill;
                        n_stopped   = 1'b1;
                    end else begin
                        // Record the loop point at the command that starts it.
                        if (r_pos == i_loop_offset) begin
                            n_loop_pos  = r_cnt;
                            n_loop_seen = 1'b1;
                        end
                        if (i_stream_byte == scsr_pkg::OP_WAIT16) begin
                            n_phase = PH_WLO;
                        end else if (i_stream_byte == scsr_pkg::OP_REGWR) begin
                            n_phase = PH_ROFF;
                        end else if (i_stream_byte == scsr_pkg::OP_WAIT735) begin
                            o_job_valid = 1'b1;
                            o_job.kind  = scsr_pkg::K_WAIT;
                            o_job.data  = {16'd0, scsr_pkg::SAMPLES_735};
                            n_cnt       = r_cnt + 32'd5;
                        end else if (i_stream_byte == scsr_pkg::OP_WAIT882) begin
                            o_job_valid = 1'b1;
                            o_job.kind  = scsr_pkg::K_WAIT;
                            o_job.data  = {16'd0, scsr_pkg::SAMPLES_882};
                            n_cnt       = r_cnt + 32'd5;
                        end else if (i_stream_byte[7:4] == scsr_pkg::OP_WAITN_HI) begin
                            o_job_valid = 1'b1;
                            o_job.kind  = scsr_pkg::K_WAIT;
                            o_job.data  = {27'd0, {1'b0, i_stream_byte[3:0]} + 5'd1};
                            n_cnt       = r_cnt + 32'd5;
                        end else begin
                            o_job_valid = 1'b1;
                            o_job.data  = {30'd0, scsr_pkg::ST_BAD_CMD};
                            n_stopped   = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CMD;
            r_operand   <= 8'd0;
            r_pos       <= scsr_pkg::POS_RESET;
            r_cnt       <= 32'd0;
            r_loop_pos  <= 32'd0;
            r_loop_seen <= 1'b0;
            r_stopped   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_operand   <= n_operand;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_loop_pos  <= n_loop_pos;
            r_loop_seen <= n_loop_seen;
            r_stopped   <= n_stopped;
        end
    end

endmodule

### rtl/core/scsr_queue.sv
// ----------------------------------------------------------------------------
// scsr_queue
// Short job queue between parser and emitter.
// ----------------------------------------------------------------------------
module scsr_queue #(
    parameter int DEPTH = scsr_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  scsr_pkg::t_job i_wr_job,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_valid,
    output scsr_pkg::t_job o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    scsr_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_mem[r_wr_ptr] <= i_wr_job;
                r_wr_ptr        <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CW'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### rtl/core/scsr_back.sv
// ----------------------------------------------------------------------------
// scsr_back
// Byte emitter: expands each job into its output bytes, one per cycle while
// results are popped, into a single output register.
// ----------------------------------------------------------------------------
module scsr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_ticks_per_sample,
    input  logic           i_head_valid,
    input  scsr_pkg::t_job i_head,
    output logic           o_head_pop,
    input  logic           i_pop,
    output logic           o_valid,
    output logic [7:0]     o_out_byte,
    output logic [1:0]     o_status,
    output logic           o_loop_seen,
    output logic           o_last
);

    logic           r_busy;
    scsr_pkg::t_job r_job;
    logic [4:0]     r_idx;
    logic [31:0]    r_reload;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic [1:0]     r_status;
    logic           r_loop_seen;
    logic           r_last;

    scsr_pkg::t_job w_cur;
    logic           w_adv;
    logic [4:0]     w_len;
    logic           w_final;
    logic [7:0]     w_byte;
    logic [31:0]    w_prod;

    assign w_cur      = r_busy ? r_job : i_head;
    assign w_adv      = (r_busy || i_head_valid) && (!r_out_valid || i_pop);
    assign o_head_pop = w_adv && !r_busy;
    assign w_final    = (r_idx == w_len - 5'd1);
    assign w_prod     = 32'(i_ticks_per_sample) * 32'(i_head.data[15:0]);

    always_comb begin
        case (w_cur.kind)
            scsr_pkg::K_WAIT: w_len = 5'd5;
            scsr_pkg::K_REG:  w_len = w_cur.flag ? 5'd6 : 5'd3;
            scsr_pkg::K_END:  w_len = 5'd5 + {1'b0, w_cur.pad};
            default:          w_len = 5'd1;
        endcase
    end

    // Later bytes of a wait come from the reload captured at job load.
    always_comb begin
        w_byte = 8'd0;
        case (w_cur.kind)
            scsr_pkg::K_WAIT: begin
                case (r_idx)
                    5'd0:    w_byte = scsr_pkg::OP_WAIT16;
                    5'd1:    w_byte = r_reload[7:0];
                    5'd2:    w_byte = r_reload[15:8];
                    5'd3:    w_byte = r_reload[23:16];
                    default: w_byte = r_reload[31:24];
                endcase
            end
            scsr_pkg::K_REG: begin
                case (r_idx)
                    5'd0:    w_byte = scsr_pkg::OP_REGWR;
                    5'd1:    w_byte = w_cur.aux;
                    5'd2:    w_byte = w_cur.data[7:0];
                    5'd3:    w_byte = scsr_pkg::OP_REGWR;
                    5'd4:    w_byte = scsr_pkg::REG_NR30;
                    default: w_byte = scsr_pkg::WAVE_FIX_VAL;
                endcase
            end
            scsr_pkg::K_END: begin
                case (r_idx)
                    5'd0:    w_byte = scsr_pkg::OP_END;
                    5'd1:    w_byte = w_cur.data[7:0];
                    5'd2:    w_byte = w_cur.data[15:8];
                    5'd3:    w_byte = w_cur.data[23:16];
                    5'd4:    w_byte = w_cur.data[31:24];
                    default: w_byte = 8'd0;
                endcase
            end
            default: w_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= w_byte;
                r_status    <= (w_cur.kind == scsr_pkg::K_ERR) ? w_cur.data[1:0]
                                                               : scsr_pkg::ST_OK;
                r_loop_seen <= (w_cur.kind == scsr_pkg::K_END) && w_cur.flag;
                r_last      <= w_final;
                if (!r_busy) begin
                    r_job    <= i_head;
                    r_reload <= 32'd0 - w_prod;
                end
                if (w_final) begin
                    r_busy <= 1'b0;
                    r_idx  <= 5'd0;
                end else begin
                    r_busy <= 1'b1;
                    r_idx  <= r_idx + 5'd1;
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_status;
    assign o_loop_seen = r_loop_seen;
    assign o_last      = r_last;

endmodule

### rtl/core/sound_command_stream_retargeter.sv
// ----------------------------------------------------------------------------
// sound_command_stream_retargeter
// Converts a sound log command stream into the target byte stream: waits
// become timer reloads, register writes are remapped, the end mark closes
// the stream with the loop position and zero fill to a multiple of 16 bytes.
// ----------------------------------------------------------------------------
// Path: the first result of a byte is registered in the job queue, then in the
//   emitter's output register, before it is on the result ports.
// Throughput: one result byte per cycle while results are popped, set by the
//   emitter's output register; a wait gives 5 bytes, a register write 3 or 6, the end sequence 5 to 20.
// Reset: synchronous, active low; clears the parser, queue and emitter and
//   loads loop_offset = 0, ticks_per_sample = 380. No clearing pass.
// ----------------------------------------------------------------------------
module sound_command_stream_retargeter #(
    parameter int QUEUE_DEPTH = scsr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_stream_byte,
    // result output
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_loop_seen,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]    r_loop_offset;
    logic [15:0]    r_ticks_per_sample;

    logic           w_cfg_wr;
    logic           w_job_valid;
    scsr_pkg::t_job w_job;
    logic           w_q_full;
    logic           w_q_valid;
    scsr_pkg::t_job w_q_head;
    logic           w_q_pop;
    logic           w_out_valid;

    // Configuration: registers sit at byte offsets 0 and 4; bit 2 selects.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == scsr_pkg::REG_IDX_TPS) ? {16'd0, r_ticks_per_sample}
                                                          : r_loop_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_offset      <= 32'd0;
            r_ticks_per_sample <= scsr_pkg::TPS_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == scsr_pkg::REG_IDX_LOOP) begin
                r_loop_offset <= pwdata;
            end else begin
                r_ticks_per_sample <= pwdata[15:0];
            end
        end
    end

    // Front: parse bytes, count outputs ahead of the emitter, find the loop.
    scsr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_stream_byte (i_stream_byte),
        .i_loop_offset (r_loop_offset),
        .i_q_full      (w_q_full),
        .o_full        (full),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job)
    );

    // Decouple the parser from the emitter so either side can stall.
    scsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_job_valid),
        .i_wr_job (w_job),
        .i_rd     (w_q_pop),
        .o_full   (w_q_full),
        .o_valid  (w_q_valid),
        .o_head   (w_q_head)
    );

    // Back: expand each job into bytes, one transaction per cycle while results are popped.
    scsr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ticks_per_sample (r_ticks_per_sample),
        .i_head_valid       (w_q_valid),
        .i_head             (w_q_head),
        .o_head_pop         (w_q_pop),
        .i_pop              (pop),
        .o_valid            (w_out_valid),
        .o_out_byte         (o_out_byte),
        .o_status           (o_status),
        .o_loop_seen        (o_loop_seen),
        .o_last             (o_last)
    );

    assign empty = !w_out_valid;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sound_command_stream_retargeter. Feeds command
// bytes through the push side, predicts the converted byte stream (timer
// reloads, remapped register writes, end sequence with zero fill, error
// transactions) and compares every popped transaction against it while
// both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int FINAL_SETTLE  = 32;
    localparam int PHASE_ITEMS   = 95;

    // Target offsets for source register offsets 0x00..0x1F, zero where the
    // offset has no counterpart. Offsets 0x20..0x2F go to wave RAM.
    localparam logic [0:31][7:0] REG_TARGET = {
        8'h60, 8'h62, 8'h63, 8'h64, 8'h65, 8'h00, 8'h68, 8'h69,
        8'h6C, 8'h6D, 8'h70, 8'h72, 8'h73, 8'h74, 8'h75, 8'h00,
        8'h78, 8'h79, 8'h7C, 8'h7D, 8'h80, 8'h81, 8'h84, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] status;
        logic       loop_seen;
        logic       last;
    } t_out_txn;

    typedef enum logic [2:0] {
        PARSE_CMD,
        PARSE_WAIT_LO,
        PARSE_WAIT_HI,
        PARSE_REG_OFF,
        PARSE_REG_DATA
    } t_parse;

    // Ways the stream can be closed; the block stops after any of them.
    typedef enum logic [1:0] {
        END_MARK,
        BAD_COMMAND,
        BAD_REGISTER,
        ZERO_WAIT
    } t_stop_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_stream_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_loop_seen;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sound_command_stream_retargeter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_stream_byte (i_stream_byte),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_loop_seen   (o_loop_seen),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: mirror of the parser, the counters and the registers
    // ------------------------------------------------------------------------
    t_out_txn    expected_out[$];   // converted bytes still owed by the block
    t_out_txn    burst[$];          // transactions caused by the current byte
    t_parse      parse_state;
    logic [7:0]  held_value;        // low wait byte or mapped register offset
    logic [31:0] in_pos;
    logic [31:0] out_count;
    logic [31:0] loop_pos;
    logic        loop_hit;
    logic        halted;
    logic [31:0] cfg_loop_offset;
    logic [15:0] cfg_ticks;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int items_sent     = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [7:0] target_offset(input logic [7:0] src);
        if (src < 8'h20) return REG_TARGET[src[4:0]];
        if (src < 8'h30) return scsr_pkg::WAVE_BASE + (src - 8'h20);
        return 8'h00;
    endfunction

    // Append one transaction; only good bytes advance the output count.
    function automatic void emit(input logic [7:0] value, input logic [1:0] status,
                                 input logic seen);
        t_out_txn txn;
        txn.value     = value;
        txn.status    = status;
        txn.loop_seen = seen;
        txn.last      = 1'b0;
        burst.push_back(txn);
        if (status == scsr_pkg::ST_OK) out_count = out_count + 1;
    endfunction

    // Wait of n samples: opcode, then 2^32 - ticks * n, lowest byte first.
    function automatic void emit_reload(input logic [15:0] samples);
        logic [31:0] reload;
        reload = 32'd0 - {16'd0, cfg_ticks} * {16'd0, samples};
        emit(scsr_pkg::OP_WAIT16, scsr_pkg::ST_OK, 1'b0);
        emit(reload[7:0], scsr_pkg::ST_OK, 1'b0);
        emit(reload[15:8], scsr_pkg::ST_OK, 1'b0);
        emit(reload[23:16], scsr_pkg::ST_OK, 1'b0);
        emit(reload[31:24], scsr_pkg::ST_OK, 1'b0);
    endfunction

    function automatic void abort_stream(input logic [1:0] status);
        emit(8'h00, status, 1'b0);
        halted = 1'b1;
    endfunction

    // Advance the predictor by one accepted command byte and queue what the
    // block owes for it, with the last flag on the final transaction.
    function automatic void retarget_byte(input logic [7:0] b);
        logic [31:0] pos;
        logic [7:0]  mapped;
        logic [7:0]  data;
        logic [3:0]  fill;
        t_out_txn    txn;
        if (halted) return;
        pos    = in_pos;
        in_pos = in_pos + 1;
        burst.delete();
        case (parse_state)
            PARSE_WAIT_LO: begin
                held_value  = b;
                parse_state = PARSE_WAIT_HI;
            end
            PARSE_WAIT_HI: begin
                parse_state = PARSE_CMD;
                if ({b, held_value} == 16'd0) abort_stream(scsr_pkg::ST_ZERO_WT);
                else emit_reload({b, held_value});
            end
            PARSE_REG_OFF: begin
                mapped = target_offset(b);
                if (mapped == 8'h00) begin
                    abort_stream(scsr_pkg::ST_BAD_REG);
                end else begin
                    held_value  = mapped;
                    parse_state = PARSE_REG_DATA;
                end
            end
            PARSE_REG_DATA: begin
                data = b;
                if (held_value == scsr_pkg::REG_NR30) data = b & scsr_pkg::MASK_NR30;
                if (held_value == scsr_pkg::REG_NR32) data = b & scsr_pkg::MASK_NR32;
                parse_state = PARSE_CMD;
                emit(scsr_pkg::OP_REGWR, scsr_pkg::ST_OK, 1'b0);
                emit(held_value, scsr_pkg::ST_OK, 1'b0);
                emit(data, scsr_pkg::ST_OK, 1'b0);
                // wave RAM writes get an unmasked fix-up write to NR30
                if (held_value[7:4] == scsr_pkg::WAVE_BASE[7:4]) begin
                    emit(scsr_pkg::OP_REGWR, scsr_pkg::ST_OK, 1'b0);
                    emit(scsr_pkg::REG_NR30, scsr_pkg::ST_OK, 1'b0);
                    emit(scsr_pkg::WAVE_FIX_VAL, scsr_pkg::ST_OK, 1'b0);
                end
            end
            default: begin
                parse_state = PARSE_CMD;
                if (b == scsr_pkg::OP_END) begin
                    emit(scsr_pkg::OP_END, scsr_pkg::ST_OK, loop_hit);
                    emit(loop_pos[7:0], scsr_pkg::ST_OK, loop_hit);
                    emit(loop_pos[15:8], scsr_pkg::ST_OK, loop_hit);
                    emit(loop_pos[23:16], scsr_pkg::ST_OK, loop_hit);
                    emit(loop_pos[31:24], scsr_pkg::ST_OK, loop_hit);
                    fill = out_count[3:0];
                    if (fill != 4'd0) begin
                        for (int i = int'(fill); i < 16; i++) begin
                            emit(8'h00, scsr_pkg::ST_OK, loop_hit);
                        end
                    end
                    halted = 1'b1;
                end else begin
                    if (pos == cfg_loop_offset) begin
                        loop_pos = out_count;
                        loop_hit = 1'b1;
                    end
                    if (b == scsr_pkg::OP_WAIT16) begin
                        parse_state = PARSE_WAIT_LO;
                    end else if (b == scsr_pkg::OP_WAIT735) begin
                        emit_reload(scsr_pkg::SAMPLES_735);
                    end else if (b == scsr_pkg::OP_WAIT882) begin
                        emit_reload(scsr_pkg::SAMPLES_882);
                    end else if (b[7:4] == scsr_pkg::OP_WAITN_HI) begin
                        emit_reload({12'd0, b[3:0]} + 16'd1);
                    end else if (b == scsr_pkg::OP_REGWR) begin
                        parse_state = PARSE_REG_OFF;
                    end else begin
                        abort_stream(scsr_pkg::ST_BAD_CMD);
                    end
                end
            end
        endcase
        if (burst.size() > 0) begin
            txn      = burst.pop_back();
            txn.last = 1'b1;
            burst.push_back(txn);
            while (burst.size() > 0) expected_out.push_back(burst.pop_front());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. Push stays high
    // after the transaction so back-to-back bytes see no bubble.
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (full !== 1'b0);
        items_sent++;
        retarget_byte(b);
    endtask

    task automatic send_wait16(input logic [15:0] samples);
        send_byte(scsr_pkg::OP_WAIT16);
        send_byte(samples[7:0]);
        send_byte(samples[15:8]);
    endtask

    task automatic send_reg_write(input logic [7:0] offset, input logic [7:0] data);
        send_byte(scsr_pkg::OP_REGWR);
        send_byte(offset);
        send_byte(data);
    endtask

    // One well-formed command with random content.
    task automatic send_random_command;
        logic [15:0] samples;
        logic [7:0]  offset;
        logic [7:0]  data;
        logic [3:0]  nibble;
        case ($urandom_range(9))
            0, 1: begin
                samples = 16'($urandom_range(16'hFFFF, 1));
                if ($urandom_range(3) == 0) samples = $urandom_range(1) ? 16'hFFFF : 16'h0001;
                send_wait16(samples);
            end
            2: send_byte(scsr_pkg::OP_WAIT735);
            3: send_byte(scsr_pkg::OP_WAIT882);
            4, 5: begin
                nibble = 4'($urandom_range(15));
                send_byte({scsr_pkg::OP_WAITN_HI, nibble});
            end
            default: begin
                // lean on the masked channel-3 registers now and then
                if ($urandom_range(4) == 0) begin
                    offset = $urandom_range(1) ? 8'h0A : 8'h0C;
                end else begin
                    do offset = 8'($urandom_range(8'h2F));
                    while (target_offset(offset) == 8'h00);
                end
                data = 8'($urandom_range(255));
                send_reg_write(offset, data);
            end
        endcase
    endtask

    // Drop push and let every owed transaction drain, then wait out the settle
    // count so the block can finish any internal work before touching registers.
    task automatic drain_results(input int settle);
        push <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write a register, then read it back in the following transfer.
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == scsr_pkg::REG_IDX_LOOP) cfg_loop_offset = value;
        else cfg_ticks = value[15:0];
        // keep psel high and turn the transfer into a read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if ((idx == scsr_pkg::REG_IDX_LOOP && prdata !== value) ||
            (idx == scsr_pkg::REG_IDX_TPS && prdata[15:0] !== value[15:0])) begin
            $display("%0t: register %0d read expected %h got %h", $time, idx, value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every wait and register-write opcode, operand extremes, register map corners, both masks and
    // both ends of wave RAM. The loop start may land on the 735 wait.
    task automatic test_directed;
        write_register(scsr_pkg::REG_IDX_LOOP,
                       $urandom_range(1) ? scsr_pkg::POS_RESET + 32'd6 : 32'd0);
        send_wait16(16'hFFFF);
        send_wait16(16'h0001);
        send_byte(scsr_pkg::OP_WAIT735);
        send_byte(scsr_pkg::OP_WAIT882);
        send_byte({scsr_pkg::OP_WAITN_HI, 4'h0});
        send_byte({scsr_pkg::OP_WAITN_HI, 4'hF});
        send_reg_write(8'h00, 8'hFF);
        send_reg_write(8'h0A, 8'hFF);
        send_reg_write(8'h0C, 8'hFF);
        send_reg_write(8'h20, 8'hA5);
        send_reg_write(8'h2F, 8'h5A);
    endtask

    // A zero tick count is taken as is and gives a reload of zero.
    task automatic test_zero_ticks;
        drain_results(SETTLE_CYCLES);
        write_register(scsr_pkg::REG_IDX_TPS, 32'd0);
        send_byte(scsr_pkg::OP_WAIT735);
        send_wait16(16'h1234);
    endtask

    // Random well-formed commands under one tick setting and one idling mix.
    // The loop start either lands somewhere in the coming bytes or is parked
    // at an extreme where it cannot match.
    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input logic [15:0] ticks);
        int first_item;
        drain_results(SETTLE_CYCLES);
        write_register(scsr_pkg::REG_IDX_TPS, {16'd0, ticks});
        if ($urandom_range(1)) begin
            write_register(scsr_pkg::REG_IDX_LOOP, in_pos + $urandom_range(40));
        end else begin
            write_register(scsr_pkg::REG_IDX_LOOP,
                           $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0);
        end
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_item     = items_sent;
        while (items_sent - first_item < PHASE_ITEMS) send_random_command();
    endtask

    // Close the stream one of four ways, then offer a few bytes that the
    // stopped block must swallow without a transaction.
    task automatic test_stream_end;
        t_stop_kind kind;
        logic [7:0] b;
        drain_results(SETTLE_CYCLES);
        kind = t_stop_kind'($urandom_range(3));
        // an end mark at the loop start must not count as a loop match
        if (kind == END_MARK && $urandom_range(1)) begin
            write_register(scsr_pkg::REG_IDX_LOOP, in_pos);
        end
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        case (kind)
            END_MARK: send_byte(scsr_pkg::OP_END);
            BAD_COMMAND: begin
                do b = 8'($urandom_range(255));
                while (b == scsr_pkg::OP_WAIT16 || b == scsr_pkg::OP_WAIT735 ||
                       b == scsr_pkg::OP_WAIT882 || b == scsr_pkg::OP_END ||
                       b == scsr_pkg::OP_REGWR || b[7:4] == scsr_pkg::OP_WAITN_HI);
                send_byte(b);
            end
            BAD_REGISTER: begin
                do b = 8'($urandom_range(255)); while (target_offset(b) != 8'h00);
                send_byte(scsr_pkg::OP_REGWR);
                send_byte(b);
            end
            default: send_wait16(16'h0000);
        endcase
        repeat (4) begin
            b = 8'($urandom_range(255));
            send_byte(b);
        end
        drain_results(FINAL_SETTLE);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: pop at random, compare each transaction field by field
    // against the oldest expectation.
    // ------------------------------------------------------------------------
    initial begin : result_check
        t_out_txn want;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && empty === 1'b0) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: expected no transaction, got out_byte %h status %0d",
                             $time, o_out_byte, o_status);
                    error_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (o_out_byte !== want.value) begin
                        $display("%0t: out_byte expected %h got %h", $time, want.value,
                                 o_out_byte);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time, want.status,
                                 o_status);
                        error_count++;
                    end
                    if (o_loop_seen !== want.loop_seen) begin
                        $display("%0t: loop_seen expected %b got %b", $time, want.loop_seen,
                                 o_loop_seen);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %b got %b", $time, want.last, o_last);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0)) quiet = 0;
            else quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_stream_byte <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        parse_state     = PARSE_CMD;
        held_value      = 8'h00;
        in_pos          = scsr_pkg::POS_RESET;
        out_count       = 32'd0;
        loop_pos        = 32'd0;
        loop_hit        = 1'b0;
        halted          = 1'b0;
        cfg_loop_offset = 32'd0;
        cfg_ticks       = scsr_pkg::TPS_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_zero_ticks();
        test_random_stream(0, 0, 16'd1);
        test_random_stream(56, 0, 16'hFFFF);
        test_random_stream(0, 56, 16'($urandom_range(16'hFFFF, 1)));
        test_random_stream(37, 37, scsr_pkg::TPS_RESET);
        test_stream_end();

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/scsr_pkg.sv
rtl/core/scsr_front.sv
rtl/core/scsr_queue.sv
rtl/core/scsr_back.sv
rtl/core/sound_command_stream_retargeter.sv
tb/sv/testbench.sv
